// File: rtl/core/assert_macros.svh
// Assertion macros used by the deframer engine (slfd_engine).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SLFD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset.
`define SLFD_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: rtl/core/slfd_pkg.sv
// Types and constants shared by the sync/length frame deframer.
package slfd_pkg;

    // Header bytes
    localparam logic [7:0] SYNC_FIRST  = 8'h94;
    localparam logic [7:0] SYNC_SECOND = 8'hC3;

    // Defaults
    localparam int unsigned  MAX_PAYLOAD_DEF = 512;
    localparam logic [15:0]  TIMEOUT_RESET   = 16'd500;
    localparam logic [15:0]  ELAPSED_MAX     = 16'hFFFF;

    // Deframer phase
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC0   = 3'd1,
        PH_SYNC1   = 3'd2,
        PH_LENHI   = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_HEADER   = 3'd1,
        ST_PAYLOAD  = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_BADSYNC  = 3'd4,
        ST_BADLEN   = 3'd5,
        ST_OVERSIZE = 3'd6,
        ST_TIMEOUT  = 3'd7
    } status_t;

    // One result beat
    typedef struct packed {
        status_t     status;
        logic [7:0]  payload_byte;
        logic [8:0]  payload_index;
        logic [15:0] frame_length;
    } result_t;

endpackage

// File: rtl/core/slfd_engine.sv
// Deframer state machine: header hunt, length check, payload count and timeout.
`include "assert_macros.svh"

module slfd_engine
    import slfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        cmd,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] timeout_ticks,
    output result_t     result
);

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);
    localparam logic [15:0]      MAX_LEN = 16'(MAX_PAYLOAD);

    phase_t           phase_reg, phase_next;
    logic [15:0]      decl_len_reg, decl_len_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             armed_reg, armed_next;
    logic [15:0]      elapsed_reg, elapsed_next;

    logic [15:0]      elapsed_inc;
    logic [15:0]      len_full;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W+8:0] index_ext;
    logic             ended;
    logic             drop;
    logic             complete_beat;
    logic             len_ok;

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            decl_len_reg <= '0;
            count_reg    <= '0;
            armed_reg    <= 1'b0;
            elapsed_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            decl_len_reg <= decl_len_next;
            count_reg    <= count_next;
            armed_reg    <= armed_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    assign elapsed_inc = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign len_full    = {decl_len_reg[15:8], rx_byte};
    assign count_inc   = count_reg + 1'b1;
    assign index_ext   = {9'b0, count_reg};

    // Advance phase and build the result for one beat
    always_comb
    begin
        phase_next    = phase_reg;
        decl_len_next = decl_len_reg;
        count_next    = count_reg;
        armed_next    = armed_reg;
        elapsed_next  = elapsed_reg;
        result        = '{status: ST_NONE, payload_byte: 8'd0,
                          payload_index: 9'd0, frame_length: 16'd0};
        ended         = 1'b0;
        drop          = 1'b0;

        if (cmd)
        begin
            // Tick: age an open frame and drop it on timeout
            if (armed_reg)
            begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= timeout_ticks)
                begin
                    drop          = 1'b1;
                    result.status = ST_TIMEOUT;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_SYNC0:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        phase_next    = PH_SYNC1;
                        result.status = ST_HEADER;
                    end
                    else
                    begin
                        drop          = 1'b1;
                        ended         = 1'b1;
                        result.status = ST_BADSYNC;
                    end
                end
                PH_SYNC1:
                begin
                    decl_len_next = {rx_byte, 8'd0};
                    phase_next    = PH_LENHI;
                    result.status = ST_HEADER;
                end
                PH_LENHI:
                begin
                    if (len_full > MAX_LEN)
                    begin
                        drop          = 1'b1;
                        ended         = 1'b1;
                        result.status = ST_BADLEN;
                    end
                    else
                    begin
                        decl_len_next = len_full;
                        phase_next    = PH_PAYLOAD;
                        result.status = ST_HEADER;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (count_reg >= MAX_CNT)
                    begin
                        drop          = 1'b1;
                        ended         = 1'b1;
                        result.status = ST_OVERSIZE;
                    end
                    else
                    begin
                        result.payload_byte  = rx_byte;
                        result.payload_index = index_ext[8:0];
                        count_next           = count_inc;
                        result.status        = ST_PAYLOAD;
                        if (16'(count_inc) == decl_len_reg)
                        begin
                            result.status       = ST_COMPLETE;
                            result.frame_length = decl_len_reg;
                            drop                = 1'b1;
                            ended               = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // Hunt for the first sync byte
                    if (rx_byte == SYNC_FIRST)
                    begin
                        phase_next    = PH_SYNC0;
                        armed_next    = 1'b1;
                        elapsed_next  = '0;
                        result.status = ST_HEADER;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase

            // Drop a still-open frame whose time is up
            if (!ended && !drop && armed_next && (elapsed_next >= timeout_ticks))
            begin
                drop   = 1'b1;
                result = '{status: ST_TIMEOUT, payload_byte: 8'd0,
                           payload_index: 9'd0, frame_length: 16'd0};
            end
        end

        if (drop)
        begin
            phase_next    = PH_HUNT;
            decl_len_next = '0;
            count_next    = '0;
            armed_next    = 1'b0;
            elapsed_next  = '0;
        end
    end

    // Completed frame carries a nonzero length within the limit
    assign complete_beat = step && (result.status == ST_COMPLETE);
    assign len_ok        = (result.frame_length != '0) && (result.frame_length <= MAX_LEN);

    `SLFD_ASSERT(a_armed_iff_open, armed_reg == (phase_reg != PH_HUNT), "timer arming off")
    `SLFD_ASSERT(a_count_bound, count_reg <= MAX_CNT, "payload count beyond maximum")
    `SLFD_ASSERT_IMP(a_complete_len, complete_beat, len_ok, "frame complete with bad length")

endmodule

// File: rtl/core/sync_length_frame_deframer.sv
// Input beat goes to the input register, its result to the result register.
// Throughput: one item per cycle while result_stall is low; set by the slfd_engine update.
// Every accepted item yields exactly one result beat.
// Reset (rst_n low, async): hunt for sync, frame state cleared, timeout_ticks = 500,
// both pipeline registers empty.
module sync_length_frame_deframer
    import slfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        cmd,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [7:0]  payload_byte,
    output logic [8:0]  payload_index,
    output logic [15:0] frame_length
);

    logic [15:0] timeout_reg;
    logic        in_valid_reg, in_valid_next;
    logic        cmd_reg;
    logic [7:0]  byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg;
    result_t     result_comb;
    logic        advance;
    logic        step;
    logic        accept;

    // Pipeline handshake
    assign advance    = !out_valid_reg || !result_stall;
    assign step       = in_valid_reg && advance;
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign in_valid_next  = accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? step : out_valid_reg;

    // Hold the timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            byte_reg <= rx_byte;
        end
    end

    // Capture the result beat
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_comb;
        end
    end

    slfd_engine #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .cmd           (cmd_reg),
        .rx_byte       (byte_reg),
        .timeout_ticks (timeout_reg),
        .result        (result_comb)
    );

    assign result_valid  = out_valid_reg;
    assign status        = result_reg.status;
    assign payload_byte  = result_reg.payload_byte;
    assign payload_index = result_reg.payload_index;
    assign frame_length  = result_reg.frame_length;

endmodule
